[src/rff_pkg.sv]
// Shared types and constants for the radial force field block.
package rff_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MODE  = 3'd5;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_FORCE = 2'd2
    } action_t;

    typedef struct packed {
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic               awake;
    } body_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
    } result_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        inner_radius;
        logic [30:0]        outer_radius;
        logic signed [31:0] force_gain;
        logic               escape_mode;
    } cfg_t;

    // classified body handed from front to back
    typedef struct packed {
        action_t     action;
        logic        zero;
        logic        neg_x;
        logic        neg_y;
        logic [30:0] mag_x;
        logic [30:0] mag_y;
        logic [62:0] sq_sum;
    } job_t;

endpackage

[src/rff_front.sv]
// Front end: offsets from centre, squared distance and classification.
module rff_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  rff_pkg::cfg_t    cfg,
    input  logic             body_valid,
    output logic             body_stall,
    input  rff_pkg::body_t   body,
    output logic             push,
    input  logic             full,
    output rff_pkg::job_t    job
);

    logic               adv;
    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay;
    logic [32:0]        outer_w;

    // stage 1
    logic        v1_reg, awake1_reg, beyond1_reg, negx1_reg, negy1_reg;
    logic [30:0] ax1_reg, ay1_reg;
    // stage 2
    logic        v2_reg, awake2_reg, beyond2_reg, negx2_reg, negy2_reg;
    logic [30:0] ax2_reg, ay2_reg;
    logic [61:0] sqx2_reg, sqy2_reg, osq2_reg, isq2_reg;
    // stage 3
    logic          v3_reg;
    rff_pkg::job_t job3_reg, job3_next;
    logic [62:0]   s2;

    assign adv        = !(v3_reg && full);
    assign body_stall = !adv;
    assign push       = v3_reg && !full;
    assign job        = job3_reg;

    assign dx      = {body.body_x[31], body.body_x} - {cfg.center_x[31], cfg.center_x};
    assign dy      = {body.body_y[31], body.body_y} - {cfg.center_y[31], cfg.center_y};
    assign ax      = dx[32] ? (~dx + 33'd1) : dx;
    assign ay      = dy[32] ? (~dy + 33'd1) : dy;
    assign outer_w = {2'b00, cfg.outer_radius};

    assign s2 = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

    always_comb
    begin
        job3_next.neg_x  = negx2_reg;
        job3_next.neg_y  = negy2_reg;
        job3_next.mag_x  = ax2_reg;
        job3_next.mag_y  = ay2_reg;
        job3_next.sq_sum = s2;
        job3_next.zero   = (s2 == 63'd0);
        if (!awake2_reg || beyond2_reg || s2 > {1'b0, osq2_reg})
        begin
            job3_next.action = rff_pkg::ACT_NONE;
        end
        else if (s2 < {1'b0, isq2_reg})
        begin
            job3_next.action = cfg.escape_mode ? rff_pkg::ACT_NONE : rff_pkg::ACT_STOP;
        end
        else
        begin
            job3_next.action = rff_pkg::ACT_FORCE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= body_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            awake1_reg  <= body.awake;
            beyond1_reg <= (ax > outer_w) || (ay > outer_w);
            negx1_reg   <= dx[32];
            negy1_reg   <= dy[32];
            ax1_reg     <= ax[30:0];
            ay1_reg     <= ay[30:0];

            awake2_reg  <= awake1_reg;
            beyond2_reg <= beyond1_reg;
            negx2_reg   <= negx1_reg;
            negy2_reg   <= negy1_reg;
            ax2_reg     <= ax1_reg;
            ay2_reg     <= ay1_reg;
            sqx2_reg    <= {31'b0, ax1_reg} * {31'b0, ax1_reg};
            sqy2_reg    <= {31'b0, ay1_reg} * {31'b0, ay1_reg};
            osq2_reg    <= {31'b0, cfg.outer_radius} * {31'b0, cfg.outer_radius};
            isq2_reg    <= {31'b0, cfg.inner_radius} * {31'b0, cfg.inner_radius};

            job3_reg    <= job3_next;
        end
    end

endmodule

[src/rff_queue.sv]
// Short FIFO of classified bodies between front and back.
module rff_queue
#(
    parameter int DEPTH = rff_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rff_pkg::job_t push_data,
    input  logic          pop,
    output rff_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    rff_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign head  = mem_reg[rd_reg];
    assign full  = (cnt_reg == FULLC);
    assign empty = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("pop from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count did not follow push");

endmodule

[src/rff_back.sv]
// Back end: pipelined square root, divide, scale and saturate.
module rff_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  rff_pkg::cfg_t    cfg,
    input  logic             empty,
    input  rff_pkg::job_t    head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output rff_pkg::result_t result
);

    localparam int SQ_N  = 32;
    localparam int DIV_N = 17;

    logic en;
    logic        gneg;
    logic [31:0] gmag;

    // square root stages
    logic          sv_reg  [SQ_N+1];
    rff_pkg::job_t sj_reg  [SQ_N+1];
    logic [63:0]   ss_reg  [SQ_N+1];
    logic [63:0]   sr_reg  [SQ_N+1];

    // divide stages
    logic          dv_reg  [DIV_N+1];
    rff_pkg::job_t dj_reg  [DIV_N+1];
    logic [31:0]   dd_reg  [DIV_N+1];
    logic [46:0]   dm_reg  [DIV_N+1];
    logic [48:0]   drx_reg [DIV_N+1];
    logic [48:0]   dry_reg [DIV_N+1];
    logic [16:0]   dqx_reg [DIV_N+1];
    logic [16:0]   dqy_reg [DIV_N+1];

    // scale stage
    logic          fv_reg;
    rff_pkg::job_t fj_reg;
    logic [47:0]   fx_reg, fy_reg;
    logic [63:0]   px, py;

    // output
    logic             ov_reg;
    rff_pkg::result_t out_reg, out_next;

    logic [31:0] root_len;
    logic [30:0] rem;
    logic [62:0] mprod;

    assign en           = !(ov_reg && result_stall);
    assign pop          = en && !empty;
    assign result_valid = ov_reg;
    assign result       = out_reg;

    assign gneg = cfg.force_gain[31];
    assign gmag = gneg ? (~cfg.force_gain + 32'd1) : cfg.force_gain;

    function automatic logic [31:0] sat(input logic [47:0] f, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = (f > 48'h0000_8000_0000) ? 32'h8000_0000 : (~f[31:0] + 32'd1);
        end
        else
        begin
            r = (f > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : f[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sj_reg[0] <= head;
            ss_reg[0] <= {1'b0, head.sq_sum};
            sr_reg[0] <= '0;
        end
    end

    // one root bit per stage, bit weight 4^(31-k)
    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        localparam logic [63:0] BITW = 64'd1 << (2 * (SQ_N - 1 - k));
        logic [63:0] trial;
        logic        ge;
        assign trial = sr_reg[k] + BITW;
        assign ge    = ss_reg[k] >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sj_reg[k+1] <= sj_reg[k];
                ss_reg[k+1] <= ge ? ss_reg[k] - trial : ss_reg[k];
                sr_reg[k+1] <= ge ? (sr_reg[k] >> 1) + BITW : sr_reg[k] >> 1;
            end
        end
    end

    // remaining distance and force magnitude
    assign root_len = sr_reg[SQ_N][31:0];
    assign rem      = cfg.outer_radius - root_len[30:0];
    assign mprod    = {31'b0, gmag} * {32'b0, rem};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dj_reg[0]  <= sj_reg[SQ_N];
            dd_reg[0]  <= root_len;
            dm_reg[0]  <= mprod[62:16];
            drx_reg[0] <= {2'b00, sj_reg[SQ_N].mag_x, 16'b0};
            dry_reg[0] <= {2'b00, sj_reg[SQ_N].mag_y, 16'b0};
            dqx_reg[0] <= '0;
            dqy_reg[0] <= '0;
        end
    end

    // restoring divide, quotient bit 16-j per stage
    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        localparam int B = DIV_N - 1 - j;
        logic [48:0] dsh;
        logic        gex, gey;
        assign dsh = {17'b0, dd_reg[j]} << B;
        assign gex = drx_reg[j] >= dsh;
        assign gey = dry_reg[j] >= dsh;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dj_reg[j+1]  <= dj_reg[j];
                dd_reg[j+1]  <= dd_reg[j];
                dm_reg[j+1]  <= dm_reg[j];
                drx_reg[j+1] <= gex ? drx_reg[j] - dsh : drx_reg[j];
                dry_reg[j+1] <= gey ? dry_reg[j] - dsh : dry_reg[j];
                dqx_reg[j+1] <= dqx_reg[j] | (17'(gex) << B);
                dqy_reg[j+1] <= dqy_reg[j] | (17'(gey) << B);
            end
        end
    end

    assign px = {47'b0, dqx_reg[DIV_N]} * {17'b0, dm_reg[DIV_N]};
    assign py = {47'b0, dqy_reg[DIV_N]} * {17'b0, dm_reg[DIV_N]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fj_reg  <= dj_reg[DIV_N];
            fx_reg  <= px[63:16];
            fy_reg  <= py[63:16];
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next.action  = fj_reg.action;
        out_next.force_x = '0;
        out_next.force_y = '0;
        if (fj_reg.action == rff_pkg::ACT_FORCE && !fj_reg.zero)
        begin
            out_next.force_x = sat(fx_reg, fj_reg.neg_x ^ gneg);
            out_next.force_y = sat(fy_reg, fj_reg.neg_y ^ gneg);
        end
    end

    // valid bits of the whole back pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= SQ_N; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= DIV_N; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
            fv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= !empty;
            for (int i = 0; i < SQ_N; i++)
            begin
                sv_reg[i+1] <= sv_reg[i];
            end
            dv_reg[0] <= sv_reg[SQ_N];
            for (int i = 0; i < DIV_N; i++)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
            fv_reg <= dv_reg[DIV_N];
            ov_reg <= fv_reg;
        end
    end

    a_quiet_force: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_reg.action != rff_pkg::ACT_FORCE)
        |-> (out_reg.force_x == 32'sd0 && out_reg.force_y == 32'sd0))
        else $error("force on a beat without force action");
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> !pop)
        else $error("queue popped while back end frozen");

endmodule

[src/radial_force_field_core.sv]
// Radial force field with linear falloff: top level and configuration registers.
// Pipeline: 3 front stages, one queue write, one root input stage, 32 square root stages,
//   1 scale, 17 divide stages, 1 multiply, 1 output.
// Throughput: one body per cycle while the result channel is not stalled, set by the
//   fully pipelined root and divide units.
// A stalled result freezes the back end; the queue absorbs the front for a while.
// Reset: asynchronous, active low; clears all valid bits and the queue, and sets
//   every configuration register to zero.
module radial_force_field_core
#(
    parameter int QUEUE_DEPTH = rff_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // body channel
    input  logic                            body_valid,
    output logic                            body_stall,
    input  rff_pkg::body_t                  body,
    // result channel
    output logic                            result_valid,
    input  logic                            result_stall,
    output rff_pkg::result_t                result,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rff_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    rff_pkg::cfg_t cfg_reg;
    rff_pkg::job_t job, head;
    logic          push, pop, full, empty;

    // writes are always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rff_pkg::REG_CENTER_X:     cfg_reg.center_x     <= cfg_data;
                rff_pkg::REG_CENTER_Y:     cfg_reg.center_y     <= cfg_data;
                rff_pkg::REG_INNER_RADIUS: cfg_reg.inner_radius <= cfg_data[30:0];
                rff_pkg::REG_OUTER_RADIUS: cfg_reg.outer_radius <= cfg_data[30:0];
                rff_pkg::REG_FORCE_GAIN:   cfg_reg.force_gain   <= cfg_data;
                rff_pkg::REG_ESCAPE_MODE:  cfg_reg.escape_mode  <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // front: offsets, squares, classification
    rff_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .body_valid (body_valid),
        .body_stall (body_stall),
        .body       (body),
        .push       (push),
        .full       (full),
        .job        (job)
    );

    rff_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    // back: distance, unit vector and force
    rff_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sim/tb_radial_force_field_core.sv]
// Self-checking testbench for the radial force field core.
module tb_radial_force_field_core;

    // Index past the last register: the core must drop the write.
    localparam logic [rff_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
    // Cycles with no beat on any channel before the run is declared hung.
    localparam int HANG_LIMIT = 4000;
    // Drain allowance: pipeline latency plus margin.
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic body_valid;
    logic body_stall;
    rff_pkg::body_t body;
    logic result_valid;
    logic result_stall;
    rff_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [rff_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // Shadow copy of the register file, updated on each accepted write.
    rff_pkg::cfg_t field_cfg;
    // Forces still owed by the core, oldest first.
    rff_pkg::result_t pending_forces[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int bodies_sent;
    int results_seen;
    int mismatches;
    int hang_count;
    int cfg_writes;

    radial_force_field_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .body_valid   (body_valid),
        .body_stall   (body_stall),
        .body         (body),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // floor(sqrt(s)), bit by bit
    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned acc;
        longint unsigned bit_w;
        acc = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > s)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (s >= acc + bit_w)
            begin
                s = s - (acc + bit_w);
                acc = (acc >> 1) + bit_w;
            end
            else
                acc = acc >> 1;
            bit_w = bit_w >> 2;
        end
        return acc;
    endfunction

    // One axis of the force: unit component times magnitude, saturated to 32 bits.
    function automatic logic [31:0] axis_force(longint d, longint unsigned span,
                                               longint unsigned mag, logic gain_neg);
        longint unsigned d_mag;
        longint unsigned unit;
        longint unsigned f;
        logic neg;
        d_mag = (d < 0) ? longint'(-d) : longint'(d);
        unit = (d_mag << 16) / span;
        f = (unit * mag) >> 16;
        neg = (d < 0) != gain_neg;
        if (neg)
        begin
            if (f > 64'h8000_0000)
                f = 64'h8000_0000;
            return 32'(64'd0 - f);
        end
        if (f > 64'h7FFF_FFFF)
            f = 64'h7FFF_FFFF;
        return 32'(f);
    endfunction

    function automatic rff_pkg::result_t field_response(rff_pkg::body_t b);
        rff_pkg::result_t r;
        longint dx;
        longint dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sq;
        longint unsigned outer;
        longint unsigned inner;
        longint unsigned root_len;
        longint unsigned gain_mag;
        longint unsigned mag;
        longint gain;
        r = '0;
        r.action = rff_pkg::ACT_NONE;
        dx = longint'(b.body_x) - longint'(field_cfg.center_x);
        dy = longint'(b.body_y) - longint'(field_cfg.center_y);
        ax = (dx < 0) ? longint'(-dx) : longint'(dx);
        ay = (dy < 0) ? longint'(-dy) : longint'(dy);
        outer = {33'd0, field_cfg.outer_radius};
        inner = {33'd0, field_cfg.inner_radius};
        if (!b.awake)
            return r;
        // beyond test comes first, so it also wins when inner exceeds outer
        if (ax > outer || ay > outer)
            return r;
        sq = ax * ax + ay * ay;
        if (sq > outer * outer)
            return r;
        if (sq < inner * inner)
        begin
            if (!field_cfg.escape_mode)
                r.action = rff_pkg::ACT_STOP;
            return r;
        end
        r.action = rff_pkg::ACT_FORCE;
        if (sq == 0)
            return r;
        root_len = floor_root(sq);
        gain = longint'(field_cfg.force_gain);
        gain_mag = (gain < 0) ? longint'(-gain) : longint'(gain);
        mag = (gain_mag * (outer - root_len)) >> 16;
        r.force_x = axis_force(dx, root_len, mag, gain < 0);
        r.force_y = axis_force(dy, root_len, mag, gain < 0);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Send one body beat; valid stays high into the next beat unless we idle.
    task automatic send_body(logic signed [31:0] x, logic signed [31:0] y, logic awake);
        rff_pkg::body_t b;
        b.body_x = x;
        b.body_y = y;
        b.awake = awake;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            body_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        body_valid <= 1'b1;
        body <= b;
        do
            @(posedge clk);
        while (body_stall);
        pending_forces.push_back(field_response(b));
        bodies_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [rff_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rff_pkg::REG_CENTER_X:     field_cfg.center_x = data;
            rff_pkg::REG_CENTER_Y:     field_cfg.center_y = data;
            rff_pkg::REG_INNER_RADIUS: field_cfg.inner_radius = data[30:0];
            rff_pkg::REG_OUTER_RADIUS: field_cfg.outer_radius = data[30:0];
            rff_pkg::REG_FORCE_GAIN:   field_cfg.force_gain = data;
            rff_pkg::REG_ESCAPE_MODE:  field_cfg.escape_mode = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        // idle with valid low so back-to-back writes never drive valid twice in one step
        @(negedge clk);
    endtask

    // Wait until every owed result is back and the pipe has emptied.
    task automatic drain();
        body_valid <= 1'b0;
        while (pending_forces.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_field(logic [31:0] cx, logic [31:0] cy, logic [31:0] inner,
                              logic [31:0] outer, logic [31:0] gain, logic esc);
        drain();
        write_reg(rff_pkg::REG_CENTER_X, cx);
        write_reg(rff_pkg::REG_CENTER_Y, cy);
        write_reg(rff_pkg::REG_INNER_RADIUS, inner);
        write_reg(rff_pkg::REG_OUTER_RADIUS, outer);
        write_reg(rff_pkg::REG_FORCE_GAIN, gain);
        write_reg(rff_pkg::REG_ESCAPE_MODE, {31'd0, esc});
    endtask

    // Position near the centre, clamped to the 32 bit range.
    function automatic logic [31:0] near_centre(logic signed [31:0] c, longint unsigned lim);
        longint p;
        longint off;
        off = longint'($urandom_range(32'(lim)));
        p = $urandom_range(1) ? longint'(c) + off : longint'(c) - off;
        if (p > 64'sh7FFF_FFFF)
            p = 64'sh7FFF_FFFF;
        if (p < -64'sh8000_0000)
            p = -64'sh8000_0000;
        return 32'(p);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Defaults after reset, then hand-picked bodies for each region.
    task automatic test_directed();
        // all-zero registers: a body on the centre sits at zero distance
        send_body(32'sd0, 32'sd0, 1'b1);
        send_body(32'sd1, 32'sd0, 1'b1);
        // centre origin, inner 1.0, outer 100.0, gain 1.0, no escape
        load_field(32'd0, 32'd0, 32'h0001_0000, 32'h0064_0000, 32'h0001_0000, 1'b0);
        send_body(32'sd0, 32'sd0, 1'b0);                       // asleep
        send_body(32'sd0, 32'sd0, 1'b1);                       // inside inner: stop
        send_body(32'sh0000_8000, -32'sh0000_8000, 1'b1);
        send_body(32'sh0065_0000, 32'sd0, 1'b1);               // beyond on x
        send_body(32'sd0, -32'sh0065_0000, 1'b1);              // beyond on y
        send_body(32'sh0050_0000, 32'sh0050_0000, 1'b1);       // beyond on diagonal
        send_body(32'sh0032_0000, 32'sd0, 1'b1);
        send_body(-32'sh0032_0000, 32'sd0, 1'b1);
        send_body(32'sd0, -32'sh0010_0000, 1'b1);
        send_body(32'sh0064_0000, 32'sd0, 1'b1);               // exactly on outer
        send_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        send_body(-32'sh8000_0000, -32'sh8000_0000, 1'b1);
        // escape mode leaves the inner disc alone
        drain();
        write_reg(rff_pkg::REG_ESCAPE_MODE, 32'd1);
        send_body(32'sd100, 32'sd0, 1'b1);
        // inner zero: the centre itself gets a zero force
        drain();
        write_reg(rff_pkg::REG_INNER_RADIUS, 32'd0);
        send_body(32'sd0, 32'sd0, 1'b1);
        // inner above outer: beyond test shadows the stop region
        drain();
        write_reg(rff_pkg::REG_INNER_RADIUS, 32'h00C8_0000);
        send_body(32'sh0001_0000, 32'sd0, 1'b1);
        send_body(32'sh00A0_0000, 32'sd0, 1'b1);
        // index past the register file is dropped
        drain();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_body(32'sh0032_0000, 32'sh0010_0000, 1'b1);
        // saturation: widest field, extreme gains, centre at the corner
        load_field(32'h8000_0000, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_body(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b1);
        send_body(-32'sh8000_0000, 32'sh0000_0001, 1'b1);
        send_body(-32'sh7FFF_0000, -32'sh7FFF_0000, 1'b1);
        drain();
        write_reg(rff_pkg::REG_FORCE_GAIN, 32'h8000_0000);
        send_body(32'sh0000_0000, -32'sh8000_0000, 1'b1);
        send_body(-32'sh8000_0000, -32'sh7F00_0000, 1'b1);
    endtask

    // Random field, then mostly bodies around the centre and some anywhere.
    task automatic test_random_field(int count);
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] outer;
        logic [31:0] inner;
        logic [31:0] gain;
        longint unsigned lim;
        cx = $urandom_range(3) == 0 ? $urandom() : $signed($urandom()) >>> $urandom_range(4, 16);
        cy = $urandom_range(3) == 0 ? $urandom() : $signed($urandom()) >>> $urandom_range(4, 16);
        outer = 32'($urandom_range(32'h7FFF_FFFF) >> $urandom_range(0, 20));
        case ($urandom_range(3))
            0: inner = 32'd0;
            1: inner = 32'($urandom_range(32'h7FFF_FFFF));   // often above outer
            default: inner = outer >> $urandom_range(1, 4);
        endcase
        gain = $signed($urandom()) >>> $urandom_range(0, 14);
        load_field(cx, cy, inner, outer, gain, 1'($urandom_range(1)));
        lim = {33'd0, outer[30:0]};
        lim = lim + lim / 4 + 1;
        repeat (count)
        begin
            if ($urandom_range(4) == 0)
                send_body($urandom(), $urandom(), 1'($urandom_range(1)));
            else
                send_body(near_centre(field_cfg.center_x, lim),
                          near_centre(field_cfg.center_y, lim),
                          $urandom_range(9) != 0);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker: sampled at the rising edge, compared with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        rff_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: action %0d fx %h fy %h",
                             result.action, result.force_x, result.force_y);
            end
            else
            begin
                want = pending_forces.pop_front();
                if (result.action !== want.action || result.force_x !== want.force_x ||
                    result.force_y !== want.force_y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: want act %0d fx %h fy %h, got act %0d fx %h fy %h",
                                 results_seen, want.action, want.force_x, want.force_y,
                                 result.action, result.force_x, result.force_y);
                end
            end
        end
    end

    // Receiver back-pressure, changed on the falling edge
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < rx_idle_pct);

    // Hang watchdog: any beat on any channel resets the count
    always @(posedge clk)
    begin
        if ((body_valid && !body_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            hang_count <= 0;
        else if (hang_count >= HANG_LIMIT)
        begin
            $display("no beat for %0d cycles, %0d results still owed",
                     hang_count, pending_forces.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            hang_count <= hang_count + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        body_valid = 1'b0;
        body = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        field_cfg = '0;
        hang_count = 0;
        bodies_sent = 0;
        results_seen = 0;
        mismatches = 0;
        cfg_writes = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_idle_pct = 19;
        rx_idle_pct = 87;
        test_directed();
        test_random_field(65);
        test_random_field(65);

        tx_idle_pct = 87;
        rx_idle_pct = 19;
        test_random_field(65);
        test_random_field(65);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_field(65);
        test_random_field(65);

        drain();
        $display("%0d bodies over several fields and idle patterns, %0d results, %0d writes",
                 bodies_sent, results_seen, cfg_writes);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
src/rff_pkg.sv
src/rff_front.sv
src/rff_queue.sv
src/rff_back.sv
src/radial_force_field_core.sv
sim/tb_radial_force_field_core.sv
